// ===== rtl/fwep_pkg.sv =====
package fwep_pkg;

    localparam int ADDR_W           = 24;
    localparam int COUNT_W          = 13;
    localparam int LEN_W            = 9;
    localparam int OFFSET_W         = 12;

    localparam int MAX_REQUEST_BYTES = 4096;
    localparam int SECTOR_BYTES      = 4096;
    localparam int PAGE_BYTES        = 256;

    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
    localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
    localparam int SEC_IDX_W    = ADDR_W - SECTOR_SHIFT;
    localparam int ERASE_CNT_W  = $clog2(MAX_REQUEST_BYTES / SECTOR_BYTES + 2);
    localparam int QUEUE_DEPTH  = 2;

    typedef enum logic [1:0] {
        KIND_ERASE   = 2'd0,
        KIND_PROGRAM = 2'd1,
        KIND_NOP     = 2'd2,
        KIND_REJECT  = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                kind;
        logic [ADDR_W-1:0]        start_address;
        logic [COUNT_W-1:0]       byte_count;
        logic [SEC_IDX_W-1:0]     first_sector;
        logic [ERASE_CNT_W-1:0]   erase_count;
    } desc_t;

    typedef struct packed {
        logic                     strobe;
        cmd_kind_t                kind;
        logic [ADDR_W-1:0]        target_address;
        logic [LEN_W-1:0]         chunk_length;
        logic [OFFSET_W-1:0]      data_offset;
        logic                     last_command;
    } result_t;

endpackage

// ===== rtl/fwep_front.sv =====
module fwep_front (
    input  logic                           start,
    input  logic [fwep_pkg::ADDR_W-1:0]    start_address,
    input  logic [fwep_pkg::COUNT_W-1:0]   byte_count,
    input  logic                           queue_full,
    output logic                           busy,
    output logic                           push,
    output fwep_pkg::desc_t                desc
);

    logic [fwep_pkg::ADDR_W:0]      sum;
    logic [fwep_pkg::ADDR_W-1:0]    end_addr;
    logic                           aligned;
    logic                           reject;
    logic [fwep_pkg::SEC_IDX_W:0]   first_wide;
    logic [fwep_pkg::SEC_IDX_W:0]   num_wide;

    assign busy     = queue_full;
    assign push     = start && !queue_full;

    assign sum      = {1'b0, start_address}
                      + {{(fwep_pkg::ADDR_W + 1 - fwep_pkg::COUNT_W){1'b0}}, byte_count};
    assign end_addr = fwep_pkg::ADDR_W'(sum - 1'b1);
    assign reject   = (byte_count > fwep_pkg::COUNT_W'(fwep_pkg::MAX_REQUEST_BYTES))
                      || (sum > {1'b1, {fwep_pkg::ADDR_W{1'b0}}});
    assign aligned  = (start_address[fwep_pkg::SECTOR_SHIFT-1:0] == '0);

    assign first_wide = {1'b0, start_address[fwep_pkg::ADDR_W-1:fwep_pkg::SECTOR_SHIFT]}
                        + {{fwep_pkg::SEC_IDX_W{1'b0}}, !aligned};
    assign num_wide   = {1'b0, end_addr[fwep_pkg::ADDR_W-1:fwep_pkg::SECTOR_SHIFT]}
                        + 1'b1 - first_wide;

    always_comb
    begin
        priority if (byte_count == '0)
        begin
            desc.kind = fwep_pkg::KIND_NOP;
        end
        else if (reject)
        begin
            desc.kind = fwep_pkg::KIND_REJECT;
        end
        else
        begin
            desc.kind = fwep_pkg::KIND_PROGRAM;
        end
        desc.start_address = start_address;
        desc.byte_count    = byte_count;
        desc.first_sector  = first_wide[fwep_pkg::SEC_IDX_W-1:0];
        desc.erase_count   = num_wide[fwep_pkg::ERASE_CNT_W-1:0];
    end

endmodule

// ===== rtl/fwep_queue.sv =====
module fwep_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fwep_pkg::desc_t   push_desc,
    input  logic              pop,
    output logic              full,
    output logic              valid,
    output fwep_pkg::desc_t   head
);

    localparam int PTR_W = $clog2(fwep_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(fwep_pkg::QUEUE_DEPTH + 1);

    fwep_pkg::desc_t     entry_reg [fwep_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wptr_reg;
    logic [PTR_W-1:0]    rptr_reg;
    logic [CNT_W-1:0]    count_reg;

    assign full  = (count_reg == CNT_W'(fwep_pkg::QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = entry_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == PTR_W'(fwep_pkg::QUEUE_DEPTH - 1)) ? '0
                            : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == PTR_W'(fwep_pkg::QUEUE_DEPTH - 1)) ? '0
                            : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/fwep_back.sv =====
module fwep_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  fwep_pkg::desc_t   q_head,
    output logic              pop,
    output fwep_pkg::result_t result
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SINGLE = 4'b0010,
        ST_ERASE  = 4'b0100,
        ST_PROG   = 4'b1000
    } state_t;

    state_t                              state_reg, state_next;
    fwep_pkg::cmd_kind_t                 kind_reg, kind_next;
    logic [fwep_pkg::ADDR_W-1:0]         start_reg, start_next;
    logic [fwep_pkg::ADDR_W-1:0]         wr_reg, wr_next;
    logic [fwep_pkg::COUNT_W-1:0]        remain_reg, remain_next;
    logic [fwep_pkg::OFFSET_W-1:0]       off_reg, off_next;
    logic [fwep_pkg::SEC_IDX_W-1:0]      sec_reg, sec_next;
    logic [fwep_pkg::ERASE_CNT_W-1:0]    left_reg, left_next;
    fwep_pkg::result_t                   result_reg, result_next;

    logic [fwep_pkg::PAGE_SHIFT:0]       room;
    logic [fwep_pkg::COUNT_W-1:0]        room_wide;
    logic [fwep_pkg::COUNT_W-1:0]        len;
    logic                                chunk_last;

    assign room       = (fwep_pkg::PAGE_SHIFT + 1)'(fwep_pkg::PAGE_BYTES)
                        - {1'b0, wr_reg[fwep_pkg::PAGE_SHIFT-1:0]};
    assign room_wide  = {{(fwep_pkg::COUNT_W - fwep_pkg::PAGE_SHIFT - 1){1'b0}}, room};
    assign len        = (remain_reg < room_wide) ? remain_reg : room_wide;
    assign chunk_last = (remain_reg == len);
    assign result     = result_reg;

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        start_next  = start_reg;
        wr_next     = wr_reg;
        remain_next = remain_reg;
        off_next    = off_reg;
        sec_next    = sec_reg;
        left_next   = left_reg;
        pop         = 1'b0;

        result_next.strobe         = 1'b0;
        result_next.kind           = kind_reg;
        result_next.target_address = start_reg;
        result_next.chunk_length   = '0;
        result_next.data_offset    = '0;
        result_next.last_command   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop         = 1'b1;
                    kind_next   = q_head.kind;
                    start_next  = q_head.start_address;
                    wr_next     = q_head.start_address;
                    remain_next = q_head.byte_count;
                    off_next    = '0;
                    sec_next    = q_head.first_sector;
                    left_next   = q_head.erase_count;
                    if (q_head.kind != fwep_pkg::KIND_PROGRAM)
                    begin
                        state_next = ST_SINGLE;
                    end
                    else if (q_head.erase_count != '0)
                    begin
                        state_next = ST_ERASE;
                    end
                    else
                    begin
                        state_next = ST_PROG;
                    end
                end
            end
            ST_SINGLE:
            begin
                result_next.strobe       = 1'b1;
                result_next.last_command = 1'b1;
                state_next               = ST_IDLE;
            end
            ST_ERASE:
            begin
                result_next.strobe         = 1'b1;
                result_next.kind           = fwep_pkg::KIND_ERASE;
                result_next.target_address = {sec_reg, {fwep_pkg::SECTOR_SHIFT{1'b0}}};
                sec_next                   = sec_reg + 1'b1;
                left_next                  = left_reg - 1'b1;
                if (left_reg == fwep_pkg::ERASE_CNT_W'(1))
                begin
                    state_next = ST_PROG;
                end
            end
            ST_PROG:
            begin
                result_next.strobe         = 1'b1;
                result_next.kind           = fwep_pkg::KIND_PROGRAM;
                result_next.target_address = wr_reg;
                result_next.chunk_length   = len[fwep_pkg::LEN_W-1:0];
                result_next.data_offset    = off_reg;
                result_next.last_command   = chunk_last;
                remain_next                = remain_reg - len;
                wr_next                    = wr_reg
                    + {{(fwep_pkg::ADDR_W - fwep_pkg::COUNT_W){1'b0}}, len};
                off_next                   = off_reg + len[fwep_pkg::OFFSET_W-1:0];
                if (chunk_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        start_reg  <= start_next;
        wr_reg     <= wr_next;
        remain_reg <= remain_next;
        off_reg    <= off_next;
        sec_reg    <= sec_next;
        left_reg   <= left_next;
    end

endmodule

// ===== rtl/flash_write_erase_page_planner_core.sv =====
// The first command of a request passes the queue entry, the sequencer state and the result register.
// The command sequencer takes the next request only after the last command of the current one,
// via its idle state; normal requests give up to 18 commands, empty and rejected ones give one.
// A two-entry request queue lets new requests in while earlier ones are being emitted.
// Reset (rst_n, asynchronous, active low) empties the queue and idles the sequencer.
// Commands are strobed for one cycle each and cannot be stalled by the receiver.
module flash_write_erase_page_planner_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [fwep_pkg::ADDR_W-1:0]       start_address,
    input  logic [fwep_pkg::COUNT_W-1:0]      byte_count,
    output logic                              result_strobe,
    output logic [1:0]                        command_kind,
    output logic [fwep_pkg::ADDR_W-1:0]       target_address,
    output logic [fwep_pkg::LEN_W-1:0]        chunk_length,
    output logic [fwep_pkg::OFFSET_W-1:0]     data_offset,
    output logic                              last_command
);

    logic               push;
    logic               pop;
    logic               queue_full;
    logic               queue_valid;
    fwep_pkg::desc_t    push_desc;
    fwep_pkg::desc_t    head_desc;
    fwep_pkg::result_t  result;

    fwep_front u_front (
        .start         (start),
        .start_address (start_address),
        .byte_count    (byte_count),
        .queue_full    (queue_full),
        .busy          (busy),
        .push          (push),
        .desc          (push_desc)
    );

    fwep_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .full      (queue_full),
        .valid     (queue_valid),
        .head      (head_desc)
    );

    fwep_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (queue_valid),
        .q_head  (head_desc),
        .pop     (pop),
        .result  (result)
    );

    assign result_strobe  = result.strobe;
    assign command_kind   = result.kind;
    assign target_address = result.target_address;
    assign chunk_length   = result.chunk_length;
    assign data_offset    = result.data_offset;
    assign last_command   = result.last_command;

endmodule

// ===== rtl/fwep_checker.sv =====
module fwep_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [fwep_pkg::ADDR_W-1:0]       start_address,
    input  logic [fwep_pkg::COUNT_W-1:0]      byte_count,
    input  logic                              result_strobe,
    input  logic [1:0]                        command_kind,
    input  logic [fwep_pkg::ADDR_W-1:0]       target_address,
    input  logic [fwep_pkg::LEN_W-1:0]        chunk_length,
    input  logic [fwep_pkg::OFFSET_W-1:0]     data_offset,
    input  logic                              last_command
);

    // Commands of one transaction leave back to back until its last command.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last_command |=> result_strobe)
        else $error("command stream of a transaction broke before its last command");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (command_kind == fwep_pkg::KIND_ERASE)
        |-> (target_address[fwep_pkg::SECTOR_SHIFT-1:0] == '0) && !last_command)
        else $error("erase command not sector aligned or marked last");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (command_kind == fwep_pkg::KIND_PROGRAM)
        |-> (chunk_length != '0))
        else $error("program chunk with zero length");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && ((command_kind == fwep_pkg::KIND_NOP)
                          || (command_kind == fwep_pkg::KIND_REJECT))
        |-> last_command && (chunk_length == '0) && (data_offset == '0))
        else $error("nop or reject command malformed");

endmodule

bind flash_write_erase_page_planner_core fwep_checker u_fwep_checker (.*);
